>>> design/steq_pkg.sv
// ----------------------------------------------------------------------------
// steq_pkg
// shared types, constants and coefficient tables of the stereo equalizer
// ----------------------------------------------------------------------------
package steq_pkg;

    localparam int TAPS         = 51;
    localparam int HALF_TAPS    = (TAPS + 1) / 2;
    localparam int BANDS        = 3;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 18;
    localparam int FRAC_BITS    = COEF_WIDTH - 1;
    localparam int PTR_WIDTH    = $clog2(TAPS);
    localparam int K_WIDTH      = $clog2(HALF_TAPS);
    localparam int CSUM_WIDTH   = COEF_WIDTH + $clog2(BANDS);
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + CSUM_WIDTH;
    localparam int ACC_WIDTH    = PROD_WIDTH + PTR_WIDTH;
    localparam int HALF_LSB     = 1 << (FRAC_BITS - 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [CSUM_WIDTH-1:0]   t_coef;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [ACC_WIDTH-1:0]    t_acc;
    typedef logic [PTR_WIDTH-1:0]           t_ptr;
    typedef logic [K_WIDTH-1:0]             t_kidx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // control from the sequencer to the mac unit
    typedef struct packed {
        logic clear;
        logic en;
    } t_mac_ctrl;

    localparam t_acc SAT_MAX = ACC_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam t_acc SAT_MIN = ~SAT_MAX;

    // half of each symmetric band, signed q1.17
    localparam int BAND_COEF [BANDS][HALF_TAPS] = '{
        // upper mids
        '{ 4157, 2182, 2123, 1628, 810, -93, -793, -1045, -751, -17,
           845, 1395, 1196, -26, -2256, -5131, -7992, -10028, -10487, -8905,
           -5254, -28, 5853, 11238, 15012, 16367 },
        // presence
        '{ 488, -65, 887, 2378, 2761, 1200, -1516, -3550, -3523, -1685,
           281, 720, -450, -1507, -353, 3434, 7647, 8632, 4015, -4992,
           -13610, -16209, -10078, 2336, 14464, 19469 },
        // brilliance
        '{ 1784, -182, -2807, -2268, 1396, 2714, 388, -745, 98, -1606,
           -4121, -361, 6513, 5020, -3546, -5576, -224, -195, -3883, 3479,
           15052, 5420, -20321, -22319, 9670, 31024 }
    };

    // combined coefficient of all bands for one folded tap
    function automatic t_coef coef_sum(input t_kidx k);
        int s;
        s = 0;
        for (int b = 0; b < BANDS; b++) begin
            s += BAND_COEF[b][k];
        end
        return CSUM_WIDTH'(s);
    endfunction

    // round to nearest with ties away from zero, then clamp
    function automatic t_sample round_sat(input t_acc acc);
        t_acc bias;
        t_acc q;
        bias = acc[ACC_WIDTH-1] ? ACC_WIDTH'(HALF_LSB - 1) : ACC_WIDTH'(HALF_LSB);
        q    = (acc + bias) >>> FRAC_BITS;
        if (q > SAT_MAX) begin
            q = SAT_MAX;
        end else if (q < SAT_MIN) begin
            q = SAT_MIN;
        end
        return q[SAMPLE_WIDTH-1:0];
    endfunction

endpackage

>>> design/steq_mac.sv
// ----------------------------------------------------------------------------
// steq_mac
// two-channel multiply-accumulate unit, one tap per cycle
// ----------------------------------------------------------------------------
module steq_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  steq_pkg::t_mac_ctrl i_ctrl,
    input  steq_pkg::t_sample   i_left,
    input  steq_pkg::t_sample   i_right,
    input  steq_pkg::t_coef     i_coef,
    output logic                o_busy,
    output steq_pkg::t_acc      o_acc_left,
    output steq_pkg::t_acc      o_acc_right
);

    logic              r_prod_vld;
    steq_pkg::t_prod   r_prod_left;
    steq_pkg::t_prod   r_prod_right;
    steq_pkg::t_acc    r_acc_left;
    steq_pkg::t_acc    r_acc_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_prod_left  <= i_left * i_coef;
            r_prod_right <= i_right * i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc_left  <= '0;
            r_acc_right <= '0;
        end else if (r_prod_vld) begin
            r_acc_left  <= r_acc_left + steq_pkg::ACC_WIDTH'(r_prod_left);
            r_acc_right <= r_acc_right + steq_pkg::ACC_WIDTH'(r_prod_right);
        end
    end

    assign o_busy      = r_prod_vld;
    assign o_acc_left  = r_acc_left;
    assign o_acc_right = r_acc_right;

endmodule

>>> design/stereo_three_band_fir_equalizer.sv
// ----------------------------------------------------------------------------
// stereo_three_band_fir_equalizer
// 51-tap stereo fir equalizer summing three symmetric bands
// ----------------------------------------------------------------------------
// Each input transaction is one stereo pair and gives exactly one filtered
// pair. The block works on one pair at a time: o_in_ready is high only while
// idle. The pair is written into the delay line at the edge that accepts it.
// The shared left/right multiplier pair then handles the taps one at a time,
// the read, multiply and accumulate stages drain, and the sum is rounded and
// saturated into the output register at the same edge that returns the block
// to idle. The delay line is a 51-entry memory with one read per cycle; that
// port and the single mac unit set how long a pair takes. A result waiting
// in the output register does not stop the next pair from being accepted,
// but the following result waits for it to be taken. The delay line reads
// as zero until written.
// ----------------------------------------------------------------------------
module stereo_three_band_fir_equalizer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [23:0]        i_left_in,
    input  logic signed [23:0]        i_right_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [23:0]        o_left_out,
    output logic signed [23:0]        o_right_out
);

    localparam int SW = steq_pkg::SAMPLE_WIDTH;

    steq_pkg::t_state    r_state, n_state;
    steq_pkg::t_ptr      r_wp, n_wp;
    steq_pkg::t_ptr      r_pos, n_pos;
    steq_pkg::t_ptr      r_tap, n_tap;

    logic [2*SW-1:0]     r_ring [steq_pkg::TAPS];
    logic [steq_pkg::TAPS-1:0] r_written;

    logic [2*SW-1:0]     r_rd_data;
    logic                r_rd_ok;
    logic                r_rd_stage;
    steq_pkg::t_coef     r_rd_coef;

    logic                r_out_valid;
    steq_pkg::t_sample   r_left_out;
    steq_pkg::t_sample   r_right_out;

    logic                w_in_xact;
    logic                w_load_out;
    logic                w_running;
    steq_pkg::t_ptr      w_tap_rev;
    steq_pkg::t_kidx     w_k;
    steq_pkg::t_mac_ctrl w_mac_ctrl;
    steq_pkg::t_sample   w_mac_left;
    steq_pkg::t_sample   w_mac_right;
    logic                w_mac_busy;
    steq_pkg::t_acc      w_acc_left;
    steq_pkg::t_acc      w_acc_right;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= steq_pkg::S_IDLE;
            r_wp    <= '0;
            r_pos   <= '0;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_pos   <= n_pos;
            r_tap   <= n_tap;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            steq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = steq_pkg::S_RUN;
                end
            end
            steq_pkg::S_RUN: begin
                if (r_tap == steq_pkg::PTR_WIDTH'(steq_pkg::TAPS - 1)) begin
                    n_state = steq_pkg::S_DRAIN;
                end
            end
            steq_pkg::S_DRAIN: begin
                if (!r_rd_stage && !w_mac_busy) begin
                    n_state = steq_pkg::S_DONE;
                end
            end
            steq_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = steq_pkg::S_IDLE;
                end
            end
            default: n_state = steq_pkg::S_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        o_in_ready = (r_state == steq_pkg::S_IDLE);
        w_in_xact  = o_in_ready && i_in_valid;
        w_running  = (r_state == steq_pkg::S_RUN);
        w_load_out = (r_state == steq_pkg::S_DONE) && (!r_out_valid || i_out_ready);

        n_wp  = r_wp;
        n_pos = r_pos;
        n_tap = r_tap;
        if (w_in_xact) begin
            n_wp  = (r_wp == steq_pkg::PTR_WIDTH'(steq_pkg::TAPS - 1)) ? '0 : r_wp + 1'b1;
            n_pos = r_wp;
            n_tap = '0;
        end else if (w_running) begin
            // walk back from the newest sample
            n_pos = (r_pos == '0) ? steq_pkg::PTR_WIDTH'(steq_pkg::TAPS - 1) : r_pos - 1'b1;
            n_tap = r_tap + 1'b1;
        end

        w_mac_ctrl.clear = w_in_xact;
        w_mac_ctrl.en    = r_rd_stage;
    end

    // fold the tap index onto the stored half of the symmetric bands
    assign w_tap_rev = steq_pkg::PTR_WIDTH'(steq_pkg::TAPS - 1) - r_tap;
    assign w_k = (r_tap < steq_pkg::PTR_WIDTH'(steq_pkg::HALF_TAPS))
               ? r_tap[steq_pkg::K_WIDTH-1:0] : w_tap_rev[steq_pkg::K_WIDTH-1:0];

    // ---------------- delay line ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_xact) begin
            r_ring[r_wp] <= {i_left_in, i_right_in};
        end
        if (w_running) begin
            r_rd_data <= r_ring[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_rd_stage <= 1'b0;
        end else begin
            if (w_in_xact) begin
                r_written[r_wp] <= 1'b1;
            end
            r_rd_stage <= w_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_running) begin
            r_rd_ok   <= r_written[r_pos];
            r_rd_coef <= steq_pkg::coef_sum(w_k);
        end
    end

    // entries never written read as zero
    assign w_mac_left  = r_rd_ok ? r_rd_data[2*SW-1:SW] : '0;
    assign w_mac_right = r_rd_ok ? r_rd_data[SW-1:0]    : '0;

    steq_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_mac_ctrl),
        .i_left      (w_mac_left),
        .i_right     (w_mac_right),
        .i_coef      (r_rd_coef),
        .o_busy      (w_mac_busy),
        .o_acc_left  (w_acc_left),
        .o_acc_right (w_acc_right)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_left_out  <= steq_pkg::round_sat(w_acc_left);
            r_right_out <= steq_pkg::round_sat(w_acc_right);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

>>> design/steq_checker.sv
// ----------------------------------------------------------------------------
// steq_checker
// port-level checks of the stereo equalizer, bound to the top level
// ----------------------------------------------------------------------------
module steq_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic signed [23:0] o_left_out,
    input  logic signed [23:0] o_right_out
);

    // reset leaves the block idle with nothing to deliver
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("block not idle after reset");

    // an accepted input transaction drops o_in_ready, the block being busy with the tap walk
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous pair in progress");

    // a new result only appears as the block returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result delivered while still filtering");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_left_out) && $stable(o_right_out))
        else $error("stalled output transaction changed");

endmodule

bind stereo_three_band_fir_equalizer steq_checker u_steq_checker (.*);
